// ===== sv/hsb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsb_pkg: shared constants for the HSB to RGB converter
// Fixed-point constants for the hue reduction and the channel scaling.
// ----------------------------------------------------------------------------
package hsb_pkg;

    typedef logic [7:0] t_chan;

    // Hue is reduced modulo a full turn and split into sixty-degree sectors.
    localparam int unsigned HUE_FULL   = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned FRAC_ONE   = 255;
    localparam int unsigned SECTOR_ONE = FRAC_ONE * SECTOR_DEG;

    // floor(h / 360) for any 16-bit h equals (h * HUE_RECIP) >> HUE_SHIFT.
    localparam int unsigned HUE_SHIFT  = 24;
    localparam int unsigned HUE_RECIP  = 46604;

    // floor(x / 15300) for x up to 255 * 15300 equals (x * DIV_RECIP) >> DIV_SHIFT.
    localparam int unsigned DIV_SHIFT  = 36;
    localparam int unsigned DIV_RECIP  = 4491470;

endpackage

// ===== sv/hsb_hue_split.sv =====
// ----------------------------------------------------------------------------
// hsb_hue_split: hue reduction and sector split
// Three register stages: reciprocal quotient, modulo 360, sector and remainder.
// ----------------------------------------------------------------------------
module hsb_hue_split (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [15:0] i_hue,
    output logic [2:0]  o_sector,
    output logic [5:0]  o_rem
);

    logic [15:0] r_hue;
    logic [7:0]  r_quot;
    logic [8:0]  r_mod;
    logic [2:0]  r_sector;
    logic [5:0]  r_rem;

    logic [31:0] w_prod;
    logic [16:0] w_sub;
    logic [2:0]  n_sector;
    logic [8:0]  w_base;
    logic [8:0]  w_rem;

    assign w_prod = 32'(i_hue) * 32'(hsb_pkg::HUE_RECIP);
    assign w_sub  = {1'b0, r_hue} - (17'(r_quot) * 17'(hsb_pkg::HUE_FULL));

    always_comb begin
        n_sector = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (r_mod >= 9'(k * hsb_pkg::SECTOR_DEG)) begin
                n_sector = 3'(k);
            end
        end
    end

    assign w_base = 9'(n_sector) * 9'(hsb_pkg::SECTOR_DEG);
    assign w_rem  = r_mod - w_base;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_hue  <= i_hue;
            r_quot <= w_prod[hsb_pkg::HUE_SHIFT +: 8];
        end
        if (i_en[1]) begin
            r_mod <= w_sub[8:0];
        end
        if (i_en[2]) begin
            r_sector <= n_sector;
            r_rem    <= w_rem[5:0];
        end
    end

    assign o_sector = r_sector;
    assign o_rem    = r_rem;

endmodule

// ===== sv/hsb_scale.sv =====
// ----------------------------------------------------------------------------
// hsb_scale: one channel term floor(v * (15300 - s * k) / 15300)
// Three register stages: s*k, the numerator product, the reciprocal quotient.
// ----------------------------------------------------------------------------
module hsb_scale (
    input  logic          i_clk,
    input  logic [2:0]    i_en,
    input  logic [7:0]    i_sat,
    input  logic [7:0]    i_val,
    input  logic [5:0]    i_k,
    output hsb_pkg::t_chan o_chan
);

    logic [13:0]    r_sk;
    logic [7:0]     r_v;
    logic [21:0]    r_num;
    hsb_pkg::t_chan r_chan;

    logic [13:0] w_diff;
    logic [44:0] w_prod;

    // s * k never exceeds 15300, so the difference stays non-negative.
    assign w_diff = 14'(hsb_pkg::SECTOR_ONE) - r_sk;
    assign w_prod = 45'(r_num) * 45'(hsb_pkg::DIV_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sk <= 14'(i_sat) * 14'(i_k);
            r_v  <= i_val;
        end
        if (i_en[1]) begin
            r_num <= 22'(r_v) * 22'(w_diff);
        end
        if (i_en[2]) begin
            r_chan <= w_prod[hsb_pkg::DIV_SHIFT +: 8];
        end
    end

    assign o_chan = r_chan;

endmodule

// ===== sv/hsb_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsb_to_rgb_converter: HSB to RGB888 and RGB565 conversion
// Seven register stages lie between an accepted input beat and the output register.
// Throughput: one beat per clock unless stalled; each of the seven stages
// moves when the next stage is empty or moving, so a stall fills bubbles first.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [15:0] o_packed_565
);

    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;

    logic [6:0] r_vld;
    logic [6:0] w_en;

    logic [7:0] r_sat [0:2];
    logic [7:0] r_val [0:2];
    logic [2:0] r_sec [0:2];
    logic [7:0] r_vd  [0:2];

    logic [2:0]     w_sector;
    logic [5:0]     w_rem;
    logic [5:0]     w_k_t;
    hsb_pkg::t_chan w_p;
    hsb_pkg::t_chan w_q;
    hsb_pkg::t_chan w_t;

    hsb_pkg::t_chan r_red, r_green, r_blue;
    hsb_pkg::t_chan n_red, n_green, n_blue;

    // A stage loads when it is empty or when the stage after it loads too.
    always_comb begin
        w_en[6] = !r_vld[6] || !i_stall;
        for (int k = 5; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // Saturation and brightness ride alongside the hue split.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_sat[0] <= i_saturation;
            r_val[0] <= i_brightness;
        end
        for (int k = 1; k < 3; k++) begin
            if (w_en[k]) begin
                r_sat[k] <= r_sat[k - 1];
                r_val[k] <= r_val[k - 1];
            end
        end
    end

    hsb_hue_split u_split (
        .i_clk    (i_clk),
        .i_en     (w_en[2:0]),
        .i_hue    (i_hue),
        .o_sector (w_sector),
        .o_rem    (w_rem)
    );

    assign w_k_t = 6'(hsb_pkg::SECTOR_DEG) - w_rem;

    // Sector and brightness ride alongside the channel scaling.
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_sec[0] <= w_sector;
            r_vd[0]  <= r_val[2];
        end
        for (int k = 1; k < 3; k++) begin
            if (w_en[k + 3]) begin
                r_sec[k] <= r_sec[k - 1];
                r_vd[k]  <= r_vd[k - 1];
            end
        end
    end

    // p is the same form as q and t with a full sector as the remainder.
    hsb_scale u_scale_p (
        .i_clk  (i_clk),
        .i_en   (w_en[5:3]),
        .i_sat  (r_sat[2]),
        .i_val  (r_val[2]),
        .i_k    (6'(hsb_pkg::SECTOR_DEG)),
        .o_chan (w_p)
    );

    hsb_scale u_scale_q (
        .i_clk  (i_clk),
        .i_en   (w_en[5:3]),
        .i_sat  (r_sat[2]),
        .i_val  (r_val[2]),
        .i_k    (w_rem),
        .o_chan (w_q)
    );

    hsb_scale u_scale_t (
        .i_clk  (i_clk),
        .i_en   (w_en[5:3]),
        .i_sat  (r_sat[2]),
        .i_val  (r_val[2]),
        .i_k    (w_k_t),
        .o_chan (w_t)
    );

    always_comb begin
        case (r_sec[2])
            SEC_RED_YEL: begin
                n_red = r_vd[2]; n_green = w_t;     n_blue = w_p;
            end
            SEC_YEL_GRN: begin
                n_red = w_q;     n_green = r_vd[2]; n_blue = w_p;
            end
            SEC_GRN_CYN: begin
                n_red = w_p;     n_green = r_vd[2]; n_blue = w_t;
            end
            SEC_CYN_BLU: begin
                n_red = w_p;     n_green = w_q;     n_blue = r_vd[2];
            end
            SEC_BLU_MAG: begin
                n_red = w_t;     n_green = w_p;     n_blue = r_vd[2];
            end
            default: begin
                n_red = r_vd[2]; n_green = w_p;     n_blue = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid      = r_vld[6];
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_packed_565 = {r_red[7:3], r_green[7:2], r_blue[7:3]};

endmodule

// ===== sv/hsb_checker.sv =====
// ----------------------------------------------------------------------------
// hsb_checker: port-level checks for the HSB to RGB converter
// Watches the handshakes and the packed word; bound to the top level below.
// ----------------------------------------------------------------------------
module hsb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [15:0] i_hue,
    input logic [7:0]  i_saturation,
    input logic [7:0]  i_brightness,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [15:0] o_packed_565
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red) && $stable(o_green)
                                  && $stable(o_blue) && $stable(o_packed_565)))
        else $error("output beat changed while stalled");

    // The pipeline only backs up from a stalled, occupied output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output");

    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_packed_565 == {o_red[7:3], o_green[7:2], o_blue[7:3]}))
        else $error("packed word does not match the channels");

    // With the output free, an accepted beat reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall
        ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted beat did not arrive in time");

endmodule

bind hsb_to_rgb_converter hsb_checker u_hsb_checker (.*);
